FILE: rtl/delta_robot_jacobian_row_unit_macros.svh
// Assertion helpers for the delta robot Jacobian row unit.
`ifndef DELTA_ROBOT_JACOBIAN_ROW_UNIT_MACROS_SVH
`define DELTA_ROBOT_JACOBIAN_ROW_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define DRJ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define DRJ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define DRJ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DRJ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/drj_pkg.sv
`default_nettype none
package drj_pkg;

    // Item formats
    typedef struct packed {
        logic [1:0]         arm_index;
        logic signed [15:0] angle_a;
        logic signed [15:0] angle_b;
        logic signed [15:0] angle_c;
    } t_drj_in;

    typedef struct packed {
        logic [1:0]         arm_out;
        logic signed [15:0] jac_x;
        logic signed [15:0] jac_y;
        logic signed [15:0] jac_z;
    } t_drj_out;

    // Arm codes with a nonzero mounting angle
    localparam logic [1:0] ARM_120 = 2'd1;
    localparam logic [1:0] ARM_240 = 2'd2;

    // Quadrant codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    // Radians to turn fraction (2^27/pi), pi in Q30, one in Q30
    localparam logic [25:0] TURN_K  = 26'd42722830;
    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [30:0] ONE_Q30 = 31'd1073741824;
    localparam logic signed [63:0] SQ3H_Q30 = 64'sd929887697;

    // Series divisors and their 2^32 reciprocals (floor)
    localparam logic [5:0] DIV_2A = 6'd42;
    localparam logic [5:0] DIV_2B = 6'd20;
    localparam logic [5:0] DIV_2C = 6'd6;
    localparam logic [5:0] DIV_CA = 6'd56;
    localparam logic [5:0] DIV_CB = 6'd30;
    localparam logic [5:0] DIV_CC = 6'd12;
    localparam logic [31:0] RCP_2A = 32'((64'd1 << 32) / 64'd42);
    localparam logic [31:0] RCP_2B = 32'((64'd1 << 32) / 64'd20);
    localparam logic [31:0] RCP_2C = 32'((64'd1 << 32) / 64'd6);
    localparam logic [31:0] RCP_CA = 32'((64'd1 << 32) / 64'd56);
    localparam logic [31:0] RCP_CB = 32'((64'd1 << 32) / 64'd30);
    localparam logic [31:0] RCP_CC = 32'((64'd1 << 32) / 64'd12);

    // Quotient estimate, at most one below floor(n/d)
    function automatic logic [29:0] div_est(input logic [29:0] n, input logic [31:0] rcp);
        logic [61:0] p;
        p = {32'd0, n} * {30'd0, rcp};
        return p[61:32];
    endfunction

    // One-step correction of the estimate
    function automatic logic [29:0] div_fix(input logic [29:0] n, input logic [29:0] est,
                                            input logic [5:0] d);
        logic [35:0] rem;
        rem = {6'd0, n} - ({6'd0, est} * {30'd0, d});
        return (rem >= {30'd0, d}) ? est + 30'd1 : est;
    endfunction

    // Q30 by Q30 product, floor back to Q30
    function automatic logic [29:0] mul_q30(input logic [29:0] a, input logic [30:0] b);
        logic [60:0] p;
        p = {31'd0, a} * {30'd0, b};
        return p[59:30];
    endfunction

    // Q60 to Q14, round half up, saturate
    function automatic logic signed [15:0] sat_q14(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = (v + (64'sd1 <<< 45)) >>> 46;
        if (r > 64'sd32767) begin
            return 16'sh7fff;
        end else if (r < -64'sd32768) begin
            return 16'sh8000;
        end else begin
            return r[15:0];
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/drj_sincos.sv
`default_nettype none
// Fourteen-stage sine/cosine of a Q4.13 angle, results in Q30.
module drj_sincos (
    input  wire logic               i_clk,
    input  wire logic [13:0]        i_ld,
    input  wire logic signed [16:0] i_ang,
    output logic signed [31:0]      o_sin,
    output logic signed [31:0]      o_cos
);
    import drj_pkg::*;

    logic signed [43:0] ph_full;
    logic [31:0] u;
    logic [61:0] mx;
    logic [59:0] xx;
    logic signed [31:0] s_sgn;
    logic signed [31:0] c_val;

    logic [31:0] r1_p;
    logic [1:0]  r2_q, r3_q, r4_q, r5_q, r6_q, r7_q, r8_q, r9_q, r10_q, r11_q, r12_q, r13_q;
    logic        r2_neg, r3_neg, r4_neg, r5_neg, r6_neg, r7_neg, r8_neg, r9_neg, r10_neg;
    logic        r11_neg, r12_neg, r13_neg;
    logic [29:0] r2_m;
    logic [29:0] r3_x, r4_x, r5_x, r6_x, r7_x, r8_x, r9_x, r10_x, r11_x, r12_x;
    logic [29:0] r4_x2, r5_x2, r6_x2, r7_x2, r8_x2, r9_x2;
    logic [29:0] r5_es, r5_ec, r8_es, r8_ec, r11_es, r11_ec;
    logic [30:0] r6_ts, r6_tc, r9_ts, r9_tc, r12_ts, r12_tc;
    logic [29:0] r7_ws, r7_wc, r8_ws, r8_wc, r10_ws, r10_wc, r11_ws, r11_wc;
    logic [29:0] r13_s, r13_w;
    logic signed [31:0] r14_sin, r14_cos;

    // Angle to phase in 2^-32 turn; the wrap is the reduction mod 2*pi
    assign ph_full = 44'(i_ang) * 44'($signed({1'b0, TURN_K}));
    assign u       = r1_p + 32'h2000_0000;
    assign mx      = {32'd0, r2_m} * {30'd0, PI_Q30};
    assign xx      = {30'd0, r3_x} * {30'd0, r3_x};

    // Phase, then quadrant and residual magnitude
    always_ff @(posedge i_clk) begin
        if (i_ld[0]) begin
            r1_p <= ph_full[40:9];
        end
        if (i_ld[1]) begin
            r2_q   <= u[31:30];
            r2_neg <= !u[29];
            r2_m   <= u[29] ? {1'b0, u[28:0]} : 30'h2000_0000 - {1'b0, u[28:0]};
        end
    end

    // Residual in radians and its square
    always_ff @(posedge i_clk) begin
        if (i_ld[2]) begin
            r3_q <= r2_q; r3_neg <= r2_neg;
            r3_x <= mx[60:31];
        end
        if (i_ld[3]) begin
            r4_q <= r3_q; r4_neg <= r3_neg; r4_x <= r3_x;
            r4_x2 <= xx[59:30];
        end
    end

    // First Horner step: estimate, correct, multiply
    always_ff @(posedge i_clk) begin
        if (i_ld[4]) begin
            r5_q <= r4_q; r5_neg <= r4_neg; r5_x <= r4_x; r5_x2 <= r4_x2;
            r5_es <= div_est(r4_x2, RCP_2A);
            r5_ec <= div_est(r4_x2, RCP_CA);
        end
        if (i_ld[5]) begin
            r6_q <= r5_q; r6_neg <= r5_neg; r6_x <= r5_x; r6_x2 <= r5_x2;
            r6_ts <= ONE_Q30 - {1'b0, div_fix(r5_x2, r5_es, DIV_2A)};
            r6_tc <= ONE_Q30 - {1'b0, div_fix(r5_x2, r5_ec, DIV_CA)};
        end
        if (i_ld[6]) begin
            r7_q <= r6_q; r7_neg <= r6_neg; r7_x <= r6_x; r7_x2 <= r6_x2;
            r7_ws <= mul_q30(r6_x2, r6_ts);
            r7_wc <= mul_q30(r6_x2, r6_tc);
        end
    end

    // Second Horner step
    always_ff @(posedge i_clk) begin
        if (i_ld[7]) begin
            r8_q <= r7_q; r8_neg <= r7_neg; r8_x <= r7_x; r8_x2 <= r7_x2;
            r8_ws <= r7_ws; r8_wc <= r7_wc;
            r8_es <= div_est(r7_ws, RCP_2B);
            r8_ec <= div_est(r7_wc, RCP_CB);
        end
        if (i_ld[8]) begin
            r9_q <= r8_q; r9_neg <= r8_neg; r9_x <= r8_x; r9_x2 <= r8_x2;
            r9_ts <= ONE_Q30 - {1'b0, div_fix(r8_ws, r8_es, DIV_2B)};
            r9_tc <= ONE_Q30 - {1'b0, div_fix(r8_wc, r8_ec, DIV_CB)};
        end
        if (i_ld[9]) begin
            r10_q <= r9_q; r10_neg <= r9_neg; r10_x <= r9_x;
            r10_ws <= mul_q30(r9_x2, r9_ts);
            r10_wc <= mul_q30(r9_x2, r9_tc);
        end
    end

    // Third Horner step (x2 rides on from r9 through r10_x2 below)
    logic [29:0] r10_x2, r11_x2, r12_x2;
    always_ff @(posedge i_clk) begin
        if (i_ld[9]) begin
            r10_x2 <= r9_x2;
        end
        if (i_ld[10]) begin
            r11_q <= r10_q; r11_neg <= r10_neg; r11_x <= r10_x; r11_x2 <= r10_x2;
            r11_ws <= r10_ws; r11_wc <= r10_wc;
            r11_es <= div_est(r10_ws, RCP_2C);
            r11_ec <= div_est(r10_wc, RCP_CC);
        end
        if (i_ld[11]) begin
            r12_q <= r11_q; r12_neg <= r11_neg; r12_x <= r11_x; r12_x2 <= r11_x2;
            r12_ts <= ONE_Q30 - {1'b0, div_fix(r11_ws, r11_es, DIV_2C)};
            r12_tc <= ONE_Q30 - {1'b0, div_fix(r11_wc, r11_ec, DIV_CC)};
        end
        if (i_ld[12]) begin
            r13_q <= r12_q; r13_neg <= r12_neg;
            r13_s <= mul_q30(r12_x, r12_ts);
            r13_w <= mul_q30(r12_x2, r12_tc);
        end
    end

    // Final cosine step, residual sign and quadrant mapping
    assign s_sgn = r13_neg ? -$signed({2'b00, r13_s}) : $signed({2'b00, r13_s});
    assign c_val = $signed({1'b0, ONE_Q30}) - $signed({3'b000, r13_w[29:1]});

    always_ff @(posedge i_clk) begin
        if (i_ld[13]) begin
            case (r13_q)
                QUAD_0: begin r14_sin <= s_sgn;  r14_cos <= c_val;  end
                QUAD_1: begin r14_sin <= c_val;  r14_cos <= -s_sgn; end
                QUAD_2: begin r14_sin <= -s_sgn; r14_cos <= -c_val; end
                default: begin r14_sin <= -c_val; r14_cos <= s_sgn; end
            endcase
        end
    end

    assign o_sin = r14_sin;
    assign o_cos = r14_cos;

endmodule
`default_nettype wire

FILE: rtl/delta_robot_jacobian_row_unit.sv
`default_nettype none
// One row of a delta robot's direct Jacobian per item: the arm number picks the
// mounting angle (arm 3 acts as arm 0), s = angle_a + angle_b is wrapped mod 2*pi,
// and x, y, z come out in signed Q2.14, rounded and saturated. The datapath is an
// 18-stage pipeline, and one item is taken every cycle while results drain. Each
// stage loads when it is empty or when the stage after it moves, so a stalled
// output fills bubbles first and o_ready only drops once all 18 stages hold
// items.
module delta_robot_jacobian_row_unit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire drj_pkg::t_drj_in i_item,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output drj_pkg::t_drj_out     o_item
);
    import drj_pkg::*;

`include "delta_robot_jacobian_row_unit_macros.svh"

    localparam int NSTG = 18;

    logic [NSTG:1]   r_vld;
    logic [NSTG+1:1] ld;

    logic [1:0]         r1_arm;
    logic signed [16:0] r1_s, r1_c;
    logic [1:0]         r_arm [2:15];
    logic signed [31:0] sin_s, cos_s, sin_c, cos_c;

    logic signed [63:0] cs_full, zz_full;
    logic signed [31:0] r16_prod, r16_cc;
    logic signed [63:0] r16_z;
    logic [1:0]         r16_arm;

    logic signed [63:0] ps_full, cc_full;
    logic signed [63:0] r17_a, r17_b;
    logic signed [31:0] r17_prod, r17_cc;
    logic signed [15:0] r17_z;
    logic [1:0]         r17_arm;
    logic               rot17;

    logic signed [63:0] cp_prod, cp_cc;
    t_drj_out           r18_out;

    // Load enables: a stage moves when empty or when its successor moves
    always_comb begin
        ld[NSTG+1] = i_ready;
        for (int k = NSTG; k >= 1; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
    end

    assign o_ready = ld[1];
    assign o_valid = r_vld[NSTG];
    assign o_item  = r18_out;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ld[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1: joint sum, exact in 17 bits
    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r1_arm <= i_item.arm_index;
            r1_s   <= 17'(i_item.angle_a) + 17'(i_item.angle_b);
            r1_c   <= 17'(i_item.angle_c);
        end
    end

    // Arm number rides alongside the trig stages
    always_ff @(posedge i_clk) begin
        if (ld[2]) begin
            r_arm[2] <= r1_arm;
        end
        for (int k = 3; k <= 15; k++) begin
            if (ld[k]) begin
                r_arm[k] <= r_arm[k-1];
            end
        end
    end

    // Stages 2 to 15: sine and cosine of both angles
    drj_sincos u_trig_s (
        .i_clk (i_clk),
        .i_ld  (ld[15:2]),
        .i_ang (r1_s),
        .o_sin (sin_s),
        .o_cos (cos_s)
    );

    drj_sincos u_trig_c (
        .i_clk (i_clk),
        .i_ld  (ld[15:2]),
        .i_ang (r1_c),
        .o_sin (sin_c),
        .o_cos (cos_c)
    );

    // Stage 16: cos(s)sin(c) back to Q30, and the raw z product
    assign cs_full = 64'(cos_s) * 64'(sin_c);
    assign zz_full = 64'(sin_s) * 64'(sin_c);

    always_ff @(posedge i_clk) begin
        if (ld[16]) begin
            r16_prod <= 32'((cs_full + (64'sd1 <<< 29)) >>> 30);
            r16_z    <= zz_full;
            r16_cc   <= cos_c;
            r16_arm  <= r_arm[15];
        end
    end

    // Stage 17: products with sin(phi), and z rounded to Q14
    assign rot17   = (r16_arm == ARM_120) || (r16_arm == ARM_240);
    assign ps_full = 64'(r16_prod) * SQ3H_Q30;
    assign cc_full = 64'(r16_cc) * SQ3H_Q30;

    always_ff @(posedge i_clk) begin
        if (ld[17]) begin
            if (!rot17) begin
                r17_a <= '0;
                r17_b <= '0;
            end else if (r16_arm == ARM_240) begin
                r17_a <= -ps_full;
                r17_b <= -cc_full;
            end else begin
                r17_a <= ps_full;
                r17_b <= cc_full;
            end
            r17_prod <= r16_prod;
            r17_cc   <= r16_cc;
            r17_z    <= sat_q14(r16_z);
            r17_arm  <= r16_arm;
        end
    end

    // Stage 18: cos(phi) terms are shifts; sum, round, saturate
    always_comb begin
        if ((r17_arm == ARM_120) || (r17_arm == ARM_240)) begin
            cp_prod = -(64'(r17_prod) <<< 29);
            cp_cc   = -(64'(r17_cc) <<< 29);
        end else begin
            cp_prod = 64'(r17_prod) <<< 30;
            cp_cc   = 64'(r17_cc) <<< 30;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[18]) begin
            r18_out.arm_out <= r17_arm;
            r18_out.jac_x   <= sat_q14(cp_prod - r17_b);
            r18_out.jac_y   <= sat_q14(r17_a + cp_cc);
            r18_out.jac_z   <= r17_z;
        end
    end

    // Input is only refused when every stage is occupied
    `DRJ_ASSERT_IMP(a_full_stall, i_clk, i_rst_n, !o_ready, &r_vld)
    // An accepted item lands in stage 1
    `DRJ_ASSERT_NXT(a_enter, i_clk, i_rst_n, i_valid && o_ready, r_vld[1])
    // sin*sin never exceeds one in magnitude
    `DRJ_ASSERT_IMP(a_z_bound, i_clk, i_rst_n, o_valid,
        (o_item.jac_z <= 16'sd16384) && (o_item.jac_z >= -16'sd16384))

endmodule
`default_nettype wire

FILE: sim/tb_delta_robot_jacobian_row_unit.sv
`timescale 1ns / 1ps
module tb_delta_robot_jacobian_row_unit;
    import drj_pkg::*;

    localparam int  PIPE_DEPTH  = 18;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  RAND_ITEMS  = 1930;
    // Q3.13 angles
    localparam logic signed [15:0] ANG_MAX     = 16'sh7fff;
    localparam logic signed [15:0] ANG_MIN     = 16'sh8000;
    localparam logic signed [15:0] ANG_HALF_PI = 16'sd12868;
    localparam logic signed [15:0] ANG_PI      = 16'sd25736;
    // Q30 constants for the trig series and mounting angle; RAD_TO_TURN is 2^27/pi
    localparam longint ONE_Q = 64'sd1073741824;
    localparam longint HALF_Q = 64'sd536870912;
    localparam longint SQ3H_Q = 64'sd929887697;
    localparam logic [63:0] RAD_TO_TURN = 64'd42722830;
    localparam logic [63:0] PI_Q = 64'd3373259426;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_ready;
    t_drj_in  i_item;
    logic     o_valid;
    logic     i_ready;
    t_drj_out o_item;

    t_drj_out row_queue[$];
    int       mismatch_count;
    int       cycle_count;
    int       stall_mode;

    delta_robot_jacobian_row_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Fixed-point sine and cosine of a Q3.13 angle, both Q30
    function automatic void calc_sin_cos(input longint ang, output longint sn,
                                         output longint cs);
        logic [63:0] prod;
        logic [31:0] phase;
        logic [31:0] u;
        logic [1:0]  quad;
        longint      resid;
        logic [63:0] m;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        longint      s0;
        longint      c0;
        prod  = ang * RAD_TO_TURN;
        phase = prod[40:9];
        u     = phase + 32'h2000_0000;
        quad  = u[31:30];
        resid = longint'({34'd0, u[29:0]}) - HALF_Q;
        m     = (resid < 0) ? -resid : resid;
        x     = (m * PI_Q) >> 31;
        x2    = (x * x) >> 30;
        t  = ONE_Q - x2 / 42;
        t  = ONE_Q - ((x2 * t) >> 30) / 20;
        t  = ONE_Q - ((x2 * t) >> 30) / 6;
        s0 = longint'((x * t) >> 30);
        if (resid < 0) s0 = -s0;
        t  = ONE_Q - x2 / 56;
        t  = ONE_Q - ((x2 * t) >> 30) / 30;
        t  = ONE_Q - ((x2 * t) >> 30) / 12;
        c0 = ONE_Q - longint'(((x2 * t) >> 30) / 2);
        case (quad)
            QUAD_0: begin sn = s0;  cs = c0;  end
            QUAD_1: begin sn = c0;  cs = -s0; end
            QUAD_2: begin sn = -s0; cs = -c0; end
            default: begin sn = -c0; cs = s0; end
        endcase
    endfunction

    // Q60 to Q14 with round half up and saturation
    function automatic logic signed [15:0] round_q14(input longint v);
        longint r;
        r = (v + (64'sd1 <<< 45)) >>> 46;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic t_drj_out jacobian_row(input t_drj_in it);
        longint   sin_s, cos_s, sin_c, cos_c, cphi, sphi, cs_sc;
        t_drj_out row;
        calc_sin_cos(longint'(it.angle_a) + longint'(it.angle_b), sin_s, cos_s);
        calc_sin_cos(longint'(it.angle_c), sin_c, cos_c);
        if (it.arm_index == ARM_120) begin
            cphi = -HALF_Q;
            sphi = SQ3H_Q;
        end else if (it.arm_index == ARM_240) begin
            cphi = -HALF_Q;
            sphi = -SQ3H_Q;
        end else begin
            // arm 3 wraps to 360 degrees, same as arm 0
            cphi = ONE_Q;
            sphi = 0;
        end
        cs_sc = (cos_s * sin_c + HALF_Q) >>> 30;
        row.arm_out = it.arm_index;
        row.jac_x   = round_q14(cs_sc * cphi - cos_c * sphi);
        row.jac_y   = round_q14(cs_sc * sphi + cos_c * cphi);
        row.jac_z   = round_q14(sin_s * sin_c);
        return row;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Drive one item and hold it until accepted
    task automatic send_row(input logic [1:0] arm, input logic signed [15:0] a,
                            input logic signed [15:0] b, input logic signed [15:0] c);
        t_drj_in it;
        it.arm_index = arm;
        it.angle_a   = a;
        it.angle_b   = b;
        it.angle_c   = c;
        @(negedge i_clk);
        i_valid = 1'b1;
        i_item  = it;
        do @(posedge i_clk); while (!o_ready);
        row_queue.push_back(jacobian_row(it));
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            i_item  = t_drj_in'($urandom);
        end
    endtask

    task automatic send_random_row();
        send_row(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // Angle extremes, quadrant points and wrap of the sum
    task automatic test_angle_extremes();
        logic signed [15:0] pts[7];
        pts = '{16'sd0, ANG_MAX, ANG_MIN, ANG_HALF_PI, -ANG_HALF_PI, ANG_PI, -ANG_PI};
        foreach (pts[i]) send_row(2'd0, pts[i], 16'sd0, pts[(i + 3) % 7]);
        send_row(2'd0, ANG_MAX, ANG_MAX, ANG_MAX);
        send_row(2'd0, ANG_MIN, ANG_MIN, ANG_MIN);
        send_row(2'd0, ANG_MAX, ANG_MIN, ANG_HALF_PI);
        send_row(2'd0, ANG_PI, ANG_PI, -ANG_PI);
        idle_cycles(3);
    endtask

    // Every arm code, arm 3 included
    task automatic test_arm_codes();
        for (int arm = 0; arm < 4; arm++) begin
            send_row(2'(arm), 16'sd0, 16'sd0, ANG_HALF_PI);
            send_row(2'(arm), ANG_HALF_PI, 16'sd0, 16'sd0);
            send_row(2'(arm), 16'($urandom), 16'($urandom), 16'($urandom));
        end
        idle_cycles(2);
    endtask

    // Let the pipeline drain fully, then send PIPE_DEPTH / 2 random items
    task automatic test_drain_pause();
        @(negedge i_clk);
        i_valid = 1'b0;
        wait (row_queue.size() == 0);
        repeat (PIPE_DEPTH / 2) send_random_row();
        idle_cycles(1);
    endtask

    // Random items in bursts with random gaps
    task automatic test_random_bursts(input int total);
        int sent;
        int burst;
        sent = 0;
        while (sent < total) begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst && sent < total; i++) begin
                send_random_row();
                sent++;
            end
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
        end
        idle_cycles(1);
    endtask

    // Receiver stall pattern, in one of four randomly chosen modes
    always @(negedge i_clk) begin
        if (cycle_count % 200 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 1) == 1);
            2: i_ready <= ($urandom_range(0, 7) != 0);
            default: i_ready <= ((cycle_count % 32) < 6);
        endcase
    end

    // Result check against the oldest expected row
    always @(posedge i_clk) begin
        t_drj_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (row_queue.size() == 0) begin
                report_mismatch("unexpected row", 1, 0);
            end else begin
                want = row_queue.pop_front();
                if (o_item.arm_out !== want.arm_out)
                    report_mismatch("arm_out", o_item.arm_out, want.arm_out);
                if (o_item.jac_x !== want.jac_x)
                    report_mismatch("jac_x", o_item.jac_x, want.jac_x);
                if (o_item.jac_y !== want.jac_y)
                    report_mismatch("jac_y", o_item.jac_y, want.jac_y);
                if (o_item.jac_z !== want.jac_z)
                    report_mismatch("jac_z", o_item.jac_z, want.jac_z);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        mismatch_count = 0;
        cycle_count    = 0;
        stall_mode     = 0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_ready        = 1'b0;
        i_item         = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_angle_extremes();
        test_arm_codes();
        test_drain_pause();
        test_random_bursts(RAND_ITEMS / 2);
        test_drain_pause();
        test_random_bursts(RAND_ITEMS / 2);

        @(negedge i_clk);
        i_valid = 1'b0;
        wait (row_queue.size() == 0);
        repeat (PIPE_DEPTH * 2) @(posedge i_clk);
        if (mismatch_count == 0 && row_queue.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
